### rtl/ssbd_pkg.sv
// shared types and constants for the start/stop byte deframer
package ssbd_pkg;

    localparam int FRAME_BYTES_DEF = 39;
    localparam int BYTE_W          = 8;
    localparam int POS_W           = 6;

    localparam logic [BYTE_W-1:0] START_BEL = 8'h07;
    localparam logic [BYTE_W-1:0] START_ACK = 8'h06;
    localparam logic [BYTE_W-1:0] START_NAK = 8'h15;
    localparam logic [BYTE_W-1:0] SOH_BYTE  = 8'h01;
    localparam logic [BYTE_W-1:0] ETB_BYTE  = 8'h17;
    localparam logic [BYTE_W-1:0] EOT_BYTE  = 8'h04;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_SOH,
        ST_BODY,
        ST_STOP,
        ST_RD,
        ST_LOAD
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clamp;      // apply overflow fall back to write position
        logic store;      // write incoming byte into frame store
        logic wr_zero;    // store at position 0
        logic wp_one;     // write position becomes 1
        logic wp_inc;     // write position advances
        logic rep_start;  // latch last position, clear read counter
        logic rd_issue;   // read frame store at read counter
        logic out_load;   // move read data into output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_start;
        logic is_soh;
        logic is_etb;
        logic is_eot;
        logic rd_last;
        logic out_free;
    } sts_t;

endpackage

### rtl/ssbd_ctrl.sv
// control state machine for the start/stop byte deframer
module ssbd_ctrl
    import ssbd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   s_tvalid,
    output logic   s_tready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT:
            begin
                if (accept && sts.is_start)
                begin
                    state_next = ST_SOH;
                end
            end
            ST_SOH:
            begin
                if (accept)
                begin
                    state_next = sts.is_soh ? ST_BODY : ST_HUNT;
                end
            end
            ST_BODY:
            begin
                if (accept)
                begin
                    state_next = sts.is_etb ? ST_STOP : ST_BODY;
                end
            end
            ST_STOP:
            begin
                if (accept)
                begin
                    if (sts.is_eot)
                    begin
                        state_next = ST_RD;
                    end
                    else if (sts.is_etb)
                    begin
                        state_next = ST_STOP;
                    end
                    else
                    begin
                        state_next = ST_BODY;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.rd_last ? ST_HUNT : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_HUNT:
            begin
                s_tready  = 1'b1;
                cmd.clamp = accept;
                if (accept && sts.is_start)
                begin
                    cmd.store   = 1'b1;
                    cmd.wr_zero = 1'b1;
                    cmd.wp_one  = 1'b1;
                end
            end
            ST_SOH:
            begin
                s_tready  = 1'b1;
                cmd.clamp = accept;
                if (accept && sts.is_soh)
                begin
                    cmd.store  = 1'b1;
                    cmd.wp_inc = 1'b1;
                end
            end
            ST_BODY:
            begin
                s_tready   = 1'b1;
                cmd.clamp  = accept;
                cmd.store  = accept;
                cmd.wp_inc = accept;
            end
            ST_STOP:
            begin
                s_tready  = 1'b1;
                cmd.clamp = accept;
                cmd.store = accept;
                if (accept)
                begin
                    // closing byte keeps the position, anything else is body
                    cmd.rep_start = sts.is_eot;
                    cmd.wp_inc    = !sts.is_eot;
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    property p_no_accept_in_replay;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_LOAD) |-> !s_tready;
    endproperty
    a_no_accept_in_replay: assert property (p_no_accept_in_replay)
        else $error("input accepted during frame replay");

    property p_close_starts_replay;
        @(posedge clk) disable iff (!rst_n)
        cmd.rep_start |=> (state_reg == ST_RD);
    endproperty
    a_close_starts_replay: assert property (p_close_starts_replay)
        else $error("closing byte did not start replay");

    property p_load_follows_read;
        @(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |=> (state_reg == ST_LOAD);
    endproperty
    a_load_follows_read: assert property (p_load_follows_read)
        else $error("read not followed by load");

endmodule

### rtl/ssbd_datapath.sv
// frame store, write position, replay counter and output register
module ssbd_datapath
    import ssbd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BYTE_W-1:0] s_tdata,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic              m_tlast
);

    localparam int AW  = $clog2(FRAME_BYTES);
    localparam int WPW = $clog2(FRAME_BYTES + 1);

    logic [BYTE_W-1:0] mem [FRAME_BYTES];

    logic [WPW-1:0]    wp_reg;
    logic [WPW-1:0]    wp_next;
    logic [WPW-1:0]    wp_eff;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_cnt_reg;
    logic [AW-1:0]     last_pos_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic              m_tvalid_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic [POS_W-1:0]  m_pos_reg;
    logic              m_tlast_reg;

    // overflow fall back: at or past the end, drop back two below it
    assign wp_eff  = (wp_reg >= WPW'(FRAME_BYTES)) ? WPW'(FRAME_BYTES - 2) : wp_reg;
    assign wr_addr = cmd.wr_zero ? '0 : wp_eff[AW-1:0];

    always_comb
    begin
        if (cmd.wp_one)
        begin
            wp_next = WPW'(1);
        end
        else if (cmd.wp_inc)
        begin
            wp_next = wp_eff + 1'b1;
        end
        else if (cmd.clamp)
        begin
            wp_next = wp_eff;
        end
        else
        begin
            wp_next = wp_reg;
        end
    end

    assign sts.is_start = (s_tdata == START_BEL) || (s_tdata == START_ACK) ||
                          (s_tdata == START_NAK);
    assign sts.is_soh   = (s_tdata == SOH_BYTE);
    assign sts.is_etb   = (s_tdata == ETB_BYTE);
    assign sts.is_eot   = (s_tdata == EOT_BYTE);
    assign sts.rd_last  = (rd_cnt_reg == last_pos_reg);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[wr_addr] <= s_tdata;
        end
        if (cmd.rd_issue)
        begin
            rdata_reg <= mem[rd_cnt_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rd_cnt_reg   <= '0;
            last_pos_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            wp_reg <= wp_next;
            if (cmd.rep_start)
            begin
                rd_cnt_reg   <= '0;
                last_pos_reg <= wp_eff[AW-1:0];
            end
            else if (cmd.out_load)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_byte_reg  <= rdata_reg;
            m_pos_reg   <= POS_W'(rd_cnt_reg);
            m_tlast_reg <= sts.rd_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_pos_reg, m_byte_reg};
    assign m_tlast  = m_tlast_reg;

    property p_load_only_when_free;
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready);
    endproperty
    a_load_only_when_free: assert property (p_load_only_when_free)
        else $error("output register overwritten while stalled");

    property p_wp_in_range;
        @(posedge clk) disable iff (!rst_n)
        wp_reg <= WPW'(FRAME_BYTES);
    endproperty
    a_wp_in_range: assert property (p_wp_in_range)
        else $error("write position beyond frame end");

    property p_replay_from_zero;
        @(posedge clk) disable iff (!rst_n)
        cmd.rep_start |=> (rd_cnt_reg == '0);
    endproperty
    a_replay_from_zero: assert property (p_replay_from_zero)
        else $error("replay not starting at position zero");

    property p_last_marked;
        @(posedge clk) disable iff (!rst_n)
        (cmd.out_load && sts.rd_last) |=> (m_tvalid_reg && m_tlast_reg);
    endproperty
    a_last_marked: assert property (p_last_marked)
        else $error("closing byte not marked last");

endmodule

### rtl/start_stop_byte_deframer_top.sv
// top level of the start/stop byte deframer
// Takes one received byte per item on the s_ side and hunts for frames: a start
// byte (0x07, 0x06 or 0x15), then 0x01, body bytes, closed by 0x17 0x04. Bytes
// outside a frame are dropped. While hunting or receiving, an input item is
// taken every cycle. When the closing 0x04 arrives, the stored frame (position 0
// through the closing byte, up to FRAME_BYTES items) is sent on the m_ side with
// m_tlast on the closing byte; s_tready stays low during that replay, in which
// each output item takes a registered frame store read, then an output
// register load that waits out any m_tready stall.
module start_stop_byte_deframer_top
    import ssbd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] frame_byte, [13:8] byte_position
    output logic              m_tlast    // frame_end
);

    cmd_t cmd;
    sts_t sts;

    ssbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssbd_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### sim/start_stop_byte_deframer_top_tb.sv
// self-checking testbench for the start/stop byte deframer
module start_stop_byte_deframer_top_tb;
    import ssbd_pkg::*;

    localparam int FRAME_BYTES    = FRAME_BYTES_DEF;
    localparam int TOTAL_ITEMS    = 350;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int TIMEOUT_CYCLES = 2000000;

    typedef enum logic [1:0] {
        HUNT_START,
        WAIT_SOH,
        IN_BODY,
        SEEN_ETB
    } phase_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              last;
    } frame_item_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;    // [7:0] rx_byte
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;    // [7:0] frame_byte, [13:8] byte_position
    logic              m_tlast;    // frame_end

    // predictor state
    logic [BYTE_W-1:0] frame_mem [FRAME_BYTES];
    logic [6:0]        wr_pos;
    phase_t            phase;

    frame_item_t       replay_q[$];
    int                err_count;
    int                sent_items;
    int                burst_left;
    bit                gaps_on;
    rx_mode_t          rx_mode;
    int                hold_left;

    start_stop_byte_deframer_top #(
        .FRAME_BYTES(FRAME_BYTES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("start_stop_byte_deframer_top_tb NOT OK");
        $finish;
    end

    function automatic void push_body(input logic [BYTE_W-1:0] b);
        frame_mem[wr_pos] = b;
        phase = (b == ETB_BYTE) ? SEEN_ETB : IN_BODY;
        wr_pos = wr_pos + 7'd1;
    endfunction

    // advances the deframer model by one received byte, queues any replay
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        frame_item_t fi;
        int          n;
        bit          is_start;

        is_start = (b == START_BEL) || (b == START_ACK) || (b == START_NAK);
        // overlong bodies keep overwriting the tail
        if (wr_pos >= FRAME_BYTES)
            wr_pos = 7'(FRAME_BYTES - 2);
        case (phase)
            HUNT_START:
                if (is_start)
                begin
                    frame_mem[0] = b;
                    wr_pos = 7'd1;
                    phase = WAIT_SOH;
                end
            WAIT_SOH:
                if (b == SOH_BYTE)
                begin
                    frame_mem[wr_pos] = b;
                    wr_pos = wr_pos + 7'd1;
                    phase = IN_BODY;
                end
                else
                    phase = HUNT_START;
            IN_BODY:
                push_body(b);
            default:
                if (b == EOT_BYTE)
                begin
                    frame_mem[wr_pos] = b;
                    phase = HUNT_START;
                    n = int'(wr_pos) + 1;
                    for (int k = 0; k < n; k++)
                    begin
                        fi.data = frame_mem[k];
                        fi.pos  = k[POS_W-1:0];
                        fi.last = (k == n - 1);
                        replay_q.push_back(fi);
                    end
                end
                else
                    push_body(b);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 40)
            $display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
        err_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        frame_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replay_q.size() == 0)
                report_mismatch("unexpected item", m_tdata, 0);
            else
            begin
                want = replay_q.pop_front();
                if (m_tdata[7:0] !== want.data)
                    report_mismatch("frame_byte", m_tdata[7:0], want.data);
                if (m_tdata[13:8] !== want.pos)
                    report_mismatch("byte_position", m_tdata[13:8], want.pos);
                if (m_tlast !== want.last)
                    report_mismatch("frame_end", m_tlast, want.last);
            end
        end
    end

    // receiver stall pattern, long hold-off counted here
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                case (rx_mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
                    default:   m_tready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;

        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(1, 8) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        deframe_byte(b);
        sent_items++;
        burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (replay_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_start();
        case ($urandom_range(0, 2))
            0:       return START_BEL;
            1:       return START_ACK;
            default: return START_NAK;
        endcase
    endfunction

    // body content leaning on the bytes that steer the framing
    function automatic logic [BYTE_W-1:0] pick_body();
        case ($urandom_range(0, 15))
            0, 1:    return ETB_BYTE;
            2:       return EOT_BYTE;
            3:       return pick_start();
            4:       return SOH_BYTE;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input logic [BYTE_W-1:0] start, input int body_len);
        send_byte(start);
        send_byte(SOH_BYTE);
        repeat (body_len) send_byte(pick_body());
        send_byte(ETB_BYTE);
        send_byte(EOT_BYTE);
    endtask

    task automatic test_basic_frames();
        send_byte(START_BEL);
        send_byte(SOH_BYTE);
        send_byte(ETB_BYTE);
        send_byte(EOT_BYTE);
        send_byte(START_ACK);
        send_byte(SOH_BYTE);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(ETB_BYTE);
        send_byte(EOT_BYTE);
        send_byte(START_NAK);
        send_byte(SOH_BYTE);
        send_byte(ETB_BYTE);
        send_byte(EOT_BYTE);
        wait_drained();
    endtask

    task automatic test_framing_errors();
        // stray bytes outside a frame
        send_byte(8'hff);
        send_byte(ETB_BYTE);
        send_byte(EOT_BYTE);
        // bad second byte, then the soh alone while hunting
        send_byte(START_BEL);
        send_byte(START_ACK);
        send_byte(SOH_BYTE);
        // lone etb stays as data, double etb still waits for eot
        send_byte(START_NAK);
        send_byte(SOH_BYTE);
        send_byte(ETB_BYTE);
        send_byte(8'haa);
        send_byte(ETB_BYTE);
        send_byte(ETB_BYTE);
        send_byte(EOT_BYTE);
        wait_drained();
    endtask

    task automatic test_long_frames();
        // lengths around and well past the store size
        send_frame(pick_start(), 35);
        send_frame(pick_start(), 36);
        send_frame(pick_start(), 60);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        rx_mode = RX_ALWAYS;
        gaps_on = 1'b0;
        hold_left = HOLD_CYCLES;
        send_frame(pick_start(), 30);
        repeat (3) send_frame(pick_start(), $urandom_range(0, 8));
        wait_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int k;

        while (sent_items < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                    send_frame(pick_start(), ($urandom_range(0, 9) == 0)
                               ? $urandom_range(30, 60) : $urandom_range(0, 12));
                7:
                begin
                    k = $urandom_range(1, 5);
                    repeat (k) send_byte(BYTE_W'($urandom_range(0, 255)));
                end
                8:
                begin
                    send_byte(pick_start());
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                end
                default:
                begin
                    // frame left open, following frames land in its body
                    send_byte(pick_start());
                    send_byte(SOH_BYTE);
                    k = $urandom_range(0, 6);
                    repeat (k) send_byte(pick_body());
                end
            endcase
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        err_count    = 0;
        sent_items   = 0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        rx_mode      = RX_RANDOM;
        hold_left    = 0;
        wr_pos       = '0;
        phase        = HUNT_START;
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_mem[i] = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_basic_frames();
        test_framing_errors();
        test_long_frames();
        test_output_backpressure();
        test_random_traffic();

        if (err_count == 0 && replay_q.size() == 0)
            $display("start_stop_byte_deframer_top_tb OK");
        else
            $display("start_stop_byte_deframer_top_tb NOT OK");
        $finish;
    end

endmodule
